>>> rtl/tpd_pkg.sv
package tpd_pkg;

    typedef enum logic [2:0] {
        PH_STATUS  = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_HEADER  = 3'd3,
        PH_PAYLOAD = 3'd4
    } tpd_phase_t;

    localparam logic [7:0] NO_TIME_BIT  = 8'h80;
    localparam logic [7:0] DEV_BASE     = 8'h41;
    localparam logic [7:0] DEV_COUNT    = 8'd10;
    localparam logic [3:0] DEV_DEFAULT  = 4'd8;
    localparam logic [7:0] INFO_COUNT   = 8'd14;
    localparam logic [3:0] INFO_DEFAULT = 4'd2;
    localparam logic [2:0] TIME_BYTES   = 3'd4;
    localparam logic [2:0] ID_BYTES     = 3'd2;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  status_byte;
        logic [15:0] packet_length;
        logic [31:0] time_stamp;
        logic [3:0]  device_index;
        logic [3:0]  info_index;
        logic [7:0]  payload_byte;
        logic        packet_last;
        logic        cut_short;
    } tpd_result_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } tpd_buf_status_t;

endpackage

>>> rtl/tpd_parser.sv
module tpd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat,
    input  logic [7:0]           in_byte,
    input  logic                 block_end,
    output logic                 res_push,
    output tpd_pkg::tpd_result_t res_data
);
    import tpd_pkg::*;

    tpd_phase_t  phase_reg, phase_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] time_reg, time_next;
    logic [3:0]  device_reg, device_next;
    logic [3:0]  info_reg, info_next;

    logic [2:0]  tsz;
    logic [15:0] count_inc;
    logic        at_len;
    logic [7:0]  dev_off;
    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        emit_cut;

    assign tsz       = (status_reg & NO_TIME_BIT) != 8'd0 ? 3'd0 : TIME_BYTES;
    assign count_inc = count_reg + 16'd1;
    assign at_len    = count_inc == length_reg;
    assign dev_off   = in_byte - DEV_BASE;

    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        length_next = length_reg;
        count_next  = count_reg;
        time_next   = time_reg;
        device_next = device_reg;
        info_next   = info_reg;
        emit        = 1'b0;
        emit_kind   = 1'b0;
        emit_byte   = 8'd0;
        emit_last   = 1'b0;
        emit_cut    = 1'b0;
        unique case (phase_reg)
            PH_LEN_LO:
            begin
                length_next = {8'd0, in_byte};
                phase_next  = block_end ? PH_STATUS : PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {in_byte, length_reg[7:0]};
                count_next  = 16'd0;
                time_next   = 32'd0;
                device_next = 4'd0;
                info_next   = 4'd0;
                if (length_next == 16'd0 || block_end)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_cut   = length_next != 16'd0;
                    phase_next = PH_STATUS;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (count_reg < {13'd0, tsz})
                begin
                    time_next[8*count_reg[1:0] +: 8] = in_byte;
                end
                else if (count_reg == {13'd0, tsz})
                begin
                    device_next = (in_byte >= DEV_BASE && dev_off < DEV_COUNT)
                                  ? dev_off[3:0] : DEV_DEFAULT;
                end
                else
                begin
                    info_next = (in_byte < INFO_COUNT) ? in_byte[3:0] : INFO_DEFAULT;
                end
                count_next = count_inc;
                // The header goes out once its last byte is in, or early when
                // the packet or the block runs out first.
                if (at_len || block_end || count_inc >= {13'd0, tsz + ID_BYTES})
                begin
                    emit       = 1'b1;
                    emit_last  = at_len || block_end;
                    emit_cut   = block_end && !at_len;
                    phase_next = (at_len || block_end) ? PH_STATUS : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                count_next = count_inc;
                emit       = 1'b1;
                emit_kind  = 1'b1;
                emit_byte  = in_byte;
                emit_last  = at_len || block_end;
                emit_cut   = block_end && !at_len;
                if (at_len || block_end)
                begin
                    phase_next = PH_STATUS;
                end
            end
            default:
            begin
                status_next = in_byte;
                phase_next  = block_end ? PH_STATUS : PH_LEN_LO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            status_reg <= 8'd0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            time_reg   <= 32'd0;
            device_reg <= 4'd0;
            info_reg   <= 4'd0;
        end
        else if (beat)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            time_reg   <= time_next;
            device_reg <= device_next;
            info_reg   <= info_next;
        end
    end

    assign res_push = beat && emit;

    always_comb
    begin
        res_data.item_kind     = emit_kind;
        res_data.status_byte   = status_next;
        res_data.packet_length = length_next;
        res_data.time_stamp    = time_next;
        res_data.device_index  = device_next;
        res_data.info_index    = info_next;
        res_data.payload_byte  = emit_byte;
        res_data.packet_last   = emit_last;
        res_data.cut_short     = emit_cut;
    end

endmodule

>>> rtl/tpd_out_buf.sv
module tpd_out_buf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  tpd_pkg::tpd_result_t     push_data,
    input  logic                     pop_stall,
    output logic                     full,
    output logic                     pop_valid,
    output tpd_pkg::tpd_result_t     pop_data,
    output tpd_pkg::tpd_buf_status_t status
);
    import tpd_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    tpd_result_t main_reg, main_next;
    tpd_result_t skid_reg, skid_next;
    logic        pop;

    assign pop = main_valid_reg && !pop_stall;

    // The skid entry only fills when a beat arrives while the main entry is
    // held; the producer is stalled as long as it is occupied.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full              = skid_valid_reg;
    assign pop_valid         = main_valid_reg;
    assign pop_data          = main_reg;
    assign status.main_valid = main_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

>>> rtl/telemetry_packet_deframer.sv
// Telemetry packet deframer.
// The src channel carries one raw byte per beat (in_byte), with block_end set
// on the last byte of a block. Each packet is a status byte, a 16-bit
// little-endian body length and the body: an optional 32-bit time stamp,
// a device byte, an info byte and then payload bytes.
// The res channel carries one header record per packet (item_kind 0), then
// one record per payload byte (item_kind 1); packet_last marks the final
// record of a packet and cut_short a packet whose block ended early.
// Throughput is one byte per cycle while src_stall is low: the phase update
// is a single pass of logic from the accepted byte into the result register.
// Each result enters the output buffer on the edge that accepts its byte.
// A two-entry output buffer keeps src accepting while res is stalled; src_stall
// rises only when both entries hold results that res has not taken.
// Reset clears the parser to wait for a status byte and empties the buffer.
module telemetry_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  in_byte,
    input  logic        block_end,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        item_kind,
    output logic [7:0]  status_byte,
    output logic [15:0] packet_length,
    output logic [31:0] time_stamp,
    output logic [3:0]  device_index,
    output logic [3:0]  info_index,
    output logic [7:0]  payload_byte,
    output logic        packet_last,
    output logic        cut_short
);
    import tpd_pkg::*;

    logic            beat;
    logic            res_push;
    tpd_result_t     res_data;
    tpd_result_t     out_data;
    logic            buf_full;
    tpd_buf_status_t buf_status;

    assign beat      = src_valid && !src_stall;
    assign src_stall = buf_full;

    tpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .in_byte   (in_byte),
        .block_end (block_end),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    tpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .pop_stall (res_stall),
        .full      (buf_full),
        .pop_valid (res_valid),
        .pop_data  (out_data),
        .status    (buf_status)
    );

    assign item_kind     = out_data.item_kind;
    assign status_byte   = out_data.status_byte;
    assign packet_length = out_data.packet_length;
    assign time_stamp    = out_data.time_stamp;
    assign device_index  = out_data.device_index;
    assign info_index    = out_data.info_index;
    assign payload_byte  = out_data.payload_byte;
    assign packet_last   = out_data.packet_last;
    assign cut_short     = out_data.cut_short;

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid |-> buf_status.main_valid)
        else $error("skid entry held while main entry is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_valid && !res_stall |=> !buf_status.skid_valid)
        else $error("skid entry not moved up after a taken result");

    a_cut_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cut_short |-> packet_last)
        else $error("truncated result not marked as last of packet");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (device_index <= 4'd9) && (info_index <= 4'd13))
        else $error("header index outside its range");

endmodule
